[hw/rtl/dque_pkg.sv]
// shared types and constants for the double-ended queue
package dque_pkg;

    localparam int unsigned DQ_DEPTH = 16;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_REAR  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_REAR   = 2'd3
    } dq_mode_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } dq_status_t;

endpackage

[hw/rtl/dque_ring_mem.sv]
// ring store: one write port, one read port with registered read data
module dque_ring_mem #(
    parameter int unsigned DEPTH = dque_pkg::DQ_DEPTH,
    parameter int unsigned IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);
    import dque_pkg::*;

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/double_ended_queue_core.sv]
// top level of the bounded double-ended queue on a ring store
//
//  channel | ports          | tuser              | tdata (lowest bit up)
//  --------+----------------+--------------------+---------------------------------
//  input   | s_tvalid/ready | mode [1:0]         | value [31:0]
//  result  | m_tvalid/ready | status [1:0]       | popped_value [31:0], entry_count
//
// one operation per cycle while the result channel is not stalled; a result
// passes the pending stage with the registered read of the ring store, then
// the output register. indices and count are updated in the cycle the beat
// is taken, so a pop right after a push reads the freshly written entry.
// reset clears indices, count and the valid flags; the store is not cleared.
// a stalled result holds the pending stage, which then holds the input side.
module double_ended_queue_core #(
    parameter int unsigned DEPTH   = dque_pkg::DQ_DEPTH,
    parameter int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int unsigned CNT_W   = $clog2(DEPTH + 1),
    parameter int unsigned MDATA_W = ((32 + CNT_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [31:0]        s_tdata,   // value [31:0]
    input  logic [1:0]         s_tuser,   // mode [1:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // popped_value [31:0], entry_count above
    output logic [1:0]         m_tuser    // status [1:0]
);
    import dque_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // queue state
    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg, rear_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // pending stage, waiting for read data
    logic             pend_valid_reg;
    logic             pend_pop_reg;
    dq_status_t       pend_status_reg;
    logic [CNT_W-1:0] pend_count_reg;

    // output register
    logic             out_valid_reg;
    logic [31:0]      out_value_reg;
    dq_status_t       out_status_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             accept;
    logic             out_free;
    logic             pend_move;
    dq_mode_t         mode;
    logic             is_full;
    logic             is_empty;
    logic [IDX_W-1:0] front_prev, front_succ, rear_prev, rear_succ;

    // store access
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_data;
    dq_status_t       status;
    logic             pop_ok;

    assign mode      = dq_mode_t'(s_tuser);
    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    assign s_tready  = !pend_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    // ring neighbours, wrapping at the last slot
    assign front_prev = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign front_succ = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign rear_prev  = (rear_reg == '0) ? LAST_IDX : rear_reg - 1'b1;
    assign rear_succ  = (rear_reg == LAST_IDX) ? '0 : rear_reg + 1'b1;

    always_comb begin
        front_next = front_reg;
        rear_next  = rear_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = rear_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg;
        status     = ST_DONE;
        pop_ok     = 1'b0;
        case (mode)
            MODE_PUSH_FRONT: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    front_next = front_prev;
                    wr_en      = accept;
                    wr_addr    = front_prev;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_PUSH_REAR: begin
                if (is_full) begin
                    status = ST_FULL;
                end else begin
                    rear_next  = rear_succ;
                    wr_en      = accept;
                    wr_addr    = rear_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            MODE_POP_FRONT: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    front_next = front_succ;
                    rd_en      = accept;
                    rd_addr    = front_reg;
                    count_next = count_reg - 1'b1;
                    pop_ok     = 1'b1;
                end
            end
            MODE_POP_REAR: begin
                if (is_empty) begin
                    status = ST_EMPTY;
                end else begin
                    rear_next  = rear_prev;
                    rd_en      = accept;
                    rd_addr    = rear_prev;
                    count_next = count_reg - 1'b1;
                    pop_ok     = 1'b1;
                end
            end
            default: begin
                status = ST_DONE;
            end
        endcase
    end

    dque_ring_mem #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ring_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg      <= '0;
            rear_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                count_reg <= count_next;
            end
            if (accept) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_move) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_move) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload of the pending stage and the output register
    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_pop_reg    <= pop_ok;
            pend_status_reg <= status;
            pend_count_reg  <= count_next;
        end
        if (pend_move) begin
            out_value_reg  <= pend_pop_reg ? rd_data : '0;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = MDATA_W'({out_count_reg, out_value_reg});

endmodule

[tb/tb_top.sv]
// self-checking testbench for the double-ended queue core on its stream ports
`timescale 1ns / 100ps

module tb_top;

    import dque_pkg::*;

    localparam int unsigned CNT_W      = $clog2(DQ_DEPTH + 1);
    localparam int unsigned MDATA_W    = ((32 + CNT_W + 7) / 8) * 8;
    localparam int unsigned CYCLE_CAP  = 400000;   // generous ceiling on the whole run
    localparam int unsigned TAIL_WAIT  = 8;        // extra wait after the drain, beyond the result latency
    localparam int unsigned RAND_OPS   = 1700;

    // one operation offered on the input channel
    typedef struct {
        dq_mode_t    mode;
        logic [31:0] value;
    } dq_op_t;

    // one result as the block should report it
    typedef struct {
        logic [31:0]      popped;
        dq_status_t       status;
        logic [CNT_W-1:0] count;
    } dq_outcome_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;
    logic [1:0]         s_tuser  = MODE_PUSH_FRONT;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [MDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;

    double_ended_queue_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // value [31:0]
        .s_tuser  (s_tuser),    // mode [1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),    // popped_value [31:0], entry_count above
        .m_tuser  (m_tuser)     // status [1:0]
    );

    // operations waiting to be driven, and results waiting to be seen
    dq_op_t      pending_ops[$];
    dq_outcome_t awaited_outcomes[$];

    // shadow copy of the ring store and its pointers
    logic [31:0]      ring_copy [DQ_DEPTH];
    int unsigned      head_slot;
    int unsigned      tail_slot;
    logic [CNT_W-1:0] fill_level;

    // idle chances in percent for each side, changed between phases
    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;

    int unsigned err_cnt     = 0;
    int unsigned cycle_cnt   = 0;
    int unsigned n_checked   = 0;
    int unsigned n_full_hits = 0;
    int unsigned n_empty_hit = 0;
    int unsigned n_pops_ok   = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ring store behaviour: works out the result of one operation and moves the shadow state
    function automatic dq_outcome_t apply_queue_op(dq_op_t op);
        dq_outcome_t res;
        res.popped = '0;
        res.status = ST_DONE;
        if (op.mode == MODE_PUSH_FRONT || op.mode == MODE_PUSH_REAR) begin
            if (fill_level >= DQ_DEPTH) begin
                res.status = ST_FULL;       // push on a full queue is dropped
            end else if (op.mode == MODE_PUSH_FRONT) begin
                head_slot = (head_slot == 0) ? DQ_DEPTH - 1 : head_slot - 1;
                ring_copy[head_slot] = op.value;
                fill_level = fill_level + 1'b1;
            end else begin
                ring_copy[tail_slot] = op.value;
                tail_slot = (tail_slot == DQ_DEPTH - 1) ? 0 : tail_slot + 1;
                fill_level = fill_level + 1'b1;
            end
        end else begin
            if (fill_level == 0) begin
                res.status = ST_EMPTY;      // pop on an empty queue leaves it alone
            end else if (op.mode == MODE_POP_FRONT) begin
                res.popped = ring_copy[head_slot];
                head_slot = (head_slot == DQ_DEPTH - 1) ? 0 : head_slot + 1;
                fill_level = fill_level - 1'b1;
                n_pops_ok++;
            end else begin
                tail_slot = (tail_slot == 0) ? DQ_DEPTH - 1 : tail_slot - 1;
                res.popped = ring_copy[tail_slot];
                fill_level = fill_level - 1'b1;
                n_pops_ok++;
            end
        end
        res.count = fill_level;
        return res;
    endfunction

    // driver: offers the next pending operation, holding the beat until it is taken
    always @(posedge aclk) begin
        dq_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                op = pending_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= op.value;
                s_tuser  <= op.mode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor: predicts on every input beat taken, checks every result beat taken
    always @(posedge aclk) begin
        dq_op_t      seen_op;
        dq_outcome_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                seen_op.mode  = dq_mode_t'(s_tuser);
                seen_op.value = s_tdata;
                awaited_outcomes.push_back(apply_queue_op(seen_op));
            end
            if (m_tvalid && m_tready) begin
                if (awaited_outcomes.size() == 0) begin
                    $error("result beat with nothing awaited: tdata %h tuser %0d",
                           m_tdata, m_tuser);
                    err_cnt++;
                end else begin
                    want = awaited_outcomes.pop_front();
                    n_checked++;
                    if (want.status == ST_FULL)  n_full_hits++;
                    if (want.status == ST_EMPTY) n_empty_hit++;
                    if (m_tdata[31:0] !== want.popped) begin
                        $error("popped_value: expected %0d, got %0d",
                               $signed(want.popped), $signed(m_tdata[31:0]));
                        err_cnt++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %s, got %0d", want.status.name(), m_tuser);
                        err_cnt++;
                    end
                    if (m_tdata[32 +: CNT_W] !== want.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.count, m_tdata[32 +: CNT_W]);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("double_ended_queue_core regression: fail");
            $finish;
        end
    end

    task automatic queue_op(dq_mode_t mode, logic [31:0] value);
        dq_op_t op;
        op.mode  = mode;
        op.value = value;
        pending_ops.push_back(op);
    endtask

    // picks a value with the extremes turning up often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // random traffic in short runs, each with its own push bias, so the
    // queue swings between empty and full and wraps both pointers
    task automatic queue_random_ops(int unsigned n);
        int unsigned push_wt;
        int unsigned left;
        int unsigned run_len;
        left = n;
        while (left > 0) begin
            case ($urandom_range(4))
                0:       push_wt = 10;
                1:       push_wt = 30;
                2:       push_wt = 50;
                3:       push_wt = 70;
                default: push_wt = 90;
            endcase
            run_len = $urandom_range(12, 48);
            if (run_len > left) run_len = left;
            repeat (run_len) begin
                if ($urandom_range(99) < push_wt)
                    queue_op($urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT,
                             pick_value());
                else
                    queue_op($urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT,
                             pick_value());
            end
            left -= run_len;
        end
    endtask

    // sender holds off until every operation is driven and every result is back;
    // sampled mid-cycle so the driver and monitor updates of the edge have settled
    task automatic wait_drained();
        @(negedge aclk);
        while (pending_ops.size() != 0 || s_tvalid || awaited_outcomes.size() != 0)
            @(negedge aclk);
        repeat (TAIL_WAIT) @(posedge aclk);
    endtask

    initial begin
        head_slot  = 0;
        tail_slot  = 0;
        fill_level = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: pops on empty, extreme values at both ends, fill to full,
        // pushes on full at both ends, then a pop whose value must be ignored
        tx_idle_pct = 17;
        rx_idle_pct = 75;
        queue_op(MODE_POP_FRONT, 32'h1234_5678);
        queue_op(MODE_POP_REAR, 32'hffff_ffff);
        queue_op(MODE_PUSH_FRONT, 32'h7fff_ffff);
        queue_op(MODE_PUSH_REAR, 32'h8000_0000);
        queue_op(MODE_POP_FRONT, 32'h0000_0000);
        queue_op(MODE_POP_REAR, 32'h0000_0000);
        for (int i = 0; i < DQ_DEPTH; i++) begin
            case (i % 4)
                0:       queue_op(MODE_PUSH_FRONT, 32'hffff_ffff);
                1:       queue_op(MODE_PUSH_REAR, 32'h0000_0000);
                2:       queue_op(MODE_PUSH_FRONT, 32'h8000_0000 + i);
                default: queue_op(MODE_PUSH_REAR, 32'h7fff_ffff - i);
            endcase
        end
        queue_op(MODE_PUSH_FRONT, 32'hdead_beef);
        queue_op(MODE_PUSH_REAR, 32'hcafe_f00d);
        queue_op(MODE_POP_FRONT, 32'hffff_ffff);

        // phase one: sender lightly idle, receiver mostly stalled; a full
        // drain part way through makes the sender wait for the pipeline
        queue_random_ops(RAND_OPS / 6);
        wait_drained();
        queue_random_ops(RAND_OPS / 6);
        wait_drained();

        // phase two: roles swapped
        tx_idle_pct = 75;
        rx_idle_pct = 17;
        queue_random_ops(RAND_OPS / 3);
        wait_drained();

        // phase three: back-to-back beats, no idling at all
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random_ops(RAND_OPS - 2 * (RAND_OPS / 6) - RAND_OPS / 3);
        wait_drained();

        if (awaited_outcomes.size() != 0) begin
            $error("%0d results never arrived", awaited_outcomes.size());
            err_cnt++;
        end

        $display("checked %0d results: %0d successful pops, %0d pops on empty, %0d pushes on full",
                 n_checked, n_pops_ok, n_empty_hit, n_full_hits);
        $display("stall mixes covered: sender-light/receiver-heavy, swapped, and none; %0d errors",
                 err_cnt);
        if (err_cnt == 0) begin
            $display("double_ended_queue_core regression: pass");
        end else begin
            $display("double_ended_queue_core regression: fail");
        end
        $finish;
    end

endmodule
